### rtl/fca_pkg.sv
// Shared definitions for the block allocation table core.
// Opcodes, status codes, field widths and parameter defaults; no dependencies.
package fca_pkg;

    localparam int LINK_W      = 12;
    localparam int OFFSET_W    = 24;
    localparam int BOFS_W      = 9;
    localparam int POS_W       = 25;

    localparam int NUM_BLOCKS_DEF   = 4096;
    localparam int BLOCK_BYTES_DEF  = 512;
    localparam int HEADER_BYTES_DEF = 16;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_SETHD  = 3'd1,
        OP_ALLOC  = 3'd2,
        OP_FREE   = 3'd3,
        OP_LINK   = 3'd4,
        OP_NEXT   = 3'd5,
        OP_LOCATE = 3'd6
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_EARLY   = 2'd2
    } status_t;

endpackage

### rtl/fat_chain_allocator_core.sv
// Block allocation table core: link table in one RAM, free-list head in a register.
// One item in flight at a time. Table reads per item: none for load/link/set/unused
// and trivial cases, one for alloc/next, one per entry walked.
// Next input is taken once the result is in the output register; m_ready low holds the core.
// Synchronous active-low reset clears control and the free head; the table
// contents are undefined until loaded. Depends on fca_pkg and fca_link_ram.
module fat_chain_allocator_core #(
    parameter int NUM_BLOCKS   = fca_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES  = fca_pkg::BLOCK_BYTES_DEF,
    parameter int HEADER_BYTES = fca_pkg::HEADER_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [2:0]                   s_opcode,
    input  logic [fca_pkg::LINK_W-1:0]   s_block_index,
    input  logic [fca_pkg::LINK_W-1:0]   s_link_value,
    input  logic [fca_pkg::OFFSET_W-1:0] s_byte_offset,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [fca_pkg::LINK_W-1:0]   m_result_block,
    output logic [fca_pkg::BOFS_W-1:0]   m_offset_in_block,
    output logic [fca_pkg::LINK_W-1:0]   m_free_head,
    output logic [1:0]                   m_status
);

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int SW = $clog2(NUM_BLOCKS + 1);
    localparam int LW = fca_pkg::LINK_W;
    localparam int PW = fca_pkg::POS_W;
    localparam logic [PW-1:0] BLK_BYTES = PW'(BLOCK_BYTES);
    localparam logic [PW-1:0] HDR_BYTES = PW'(HEADER_BYTES);
    localparam logic [SW-1:0] STEP_MAX  = SW'(NUM_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    function automatic logic in_tab(input logic [LW-1:0] x);
        return 32'(x) < NUM_BLOCKS;
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [LW-1:0] x);
        logic [31:0] e;
        e = 32'(x);
        return e[AW-1:0];
    endfunction

    state_t               state_reg, state_next;
    fca_pkg::opcode_t     op_reg, op_next;
    logic [LW-1:0]        blk_reg, blk_next;
    logic [LW-1:0]        cur_reg, cur_next;
    logic [PW-1:0]        rem_reg, rem_next;
    logic [SW-1:0]        steps_reg, steps_next;
    logic [LW-1:0]        head_reg, head_next;
    logic [LW-1:0]        res_reg, res_next;
    logic [fca_pkg::BOFS_W-1:0] ofs_reg, ofs_next;
    fca_pkg::status_t     st_reg, st_next;
    logic                 m_valid_reg, m_valid_next;
    logic [LW-1:0]        m_res_reg, m_head_reg;
    logic [fca_pkg::BOFS_W-1:0] m_ofs_reg;
    logic [1:0]           m_st_reg;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [LW-1:0]        wr_data;
    logic [LW-1:0]        rd_data;
    logic [LW-1:0]        nx;
    logic                 nx_end;
    logic [PW-1:0]        pos_in;
    logic [PW-1:0]        rem_sub;
    logic                 accept;
    logic                 out_load;

    fca_link_ram #(.DEPTH(NUM_BLOCKS)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (to_addr(cur_reg)),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign nx       = in_tab(cur_reg) ? rd_data : '0;
    assign nx_end   = (nx == '0) || !in_tab(nx);
    assign pos_in   = PW'(s_byte_offset) + HDR_BYTES;
    assign rem_sub  = rem_reg - BLK_BYTES;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = to_addr(cur_reg);
        wr_data = '0;
        if (accept && (s_opcode == fca_pkg::OP_LOAD || s_opcode == fca_pkg::OP_LINK)
            && in_tab(s_block_index)) begin
            wr_en   = 1'b1;
            wr_addr = to_addr(s_block_index);
            wr_data = s_link_value;
        end else if (state_reg == S_EVAL && op_reg == fca_pkg::OP_ALLOC) begin
            wr_en   = in_tab(cur_reg);
        end else if (state_reg == S_EVAL && op_reg == fca_pkg::OP_FREE && nx_end) begin
            wr_en   = 1'b1;
            wr_data = head_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        blk_next     = blk_reg;
        cur_next     = cur_reg;
        rem_next     = rem_reg;
        steps_next   = steps_reg;
        head_next    = head_reg;
        res_next     = res_reg;
        ofs_next     = ofs_reg;
        st_next      = st_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next    = fca_pkg::opcode_t'(s_opcode);
                    blk_next   = s_block_index;
                    cur_next   = s_block_index;
                    rem_next   = pos_in;
                    steps_next = '0;
                    res_next   = '0;
                    ofs_next   = '0;
                    st_next    = fca_pkg::ST_OK;
                    state_next = S_DONE;
                    case (s_opcode)
                        fca_pkg::OP_SETHD: head_next = s_link_value;
                        fca_pkg::OP_ALLOC: begin
                            if (head_reg == '0) begin
                                st_next = fca_pkg::ST_NOSPACE;
                            end else begin
                                cur_next   = head_reg;
                                state_next = S_READ;
                            end
                        end
                        fca_pkg::OP_FREE: begin
                            if (s_block_index != '0 && in_tab(s_block_index)) begin
                                state_next = S_READ;
                            end
                        end
                        fca_pkg::OP_NEXT: state_next = S_READ;
                        fca_pkg::OP_LOCATE: begin
                            if (s_block_index == '0) begin
                                st_next = fca_pkg::ST_EARLY;
                            end else if (pos_in < BLK_BYTES) begin
                                res_next = s_block_index;
                                ofs_next = pos_in[fca_pkg::BOFS_W-1:0];
                            end else begin
                                state_next = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: state_next = S_EVAL;
            S_EVAL: begin
                state_next = S_DONE;
                case (op_reg)
                    fca_pkg::OP_ALLOC: begin
                        res_next  = cur_reg;
                        head_next = nx;
                    end
                    fca_pkg::OP_NEXT: res_next = nx;
                    fca_pkg::OP_FREE: begin
                        if (nx_end) begin
                            head_next = blk_reg;
                        end else if (steps_reg == STEP_MAX) begin
                            st_next = fca_pkg::ST_EARLY;
                        end else begin
                            cur_next   = nx;
                            steps_next = steps_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                    fca_pkg::OP_LOCATE: begin
                        rem_next = rem_sub;
                        cur_next = nx;
                        if (nx == '0) begin
                            st_next = fca_pkg::ST_EARLY;
                        end else if (rem_sub < BLK_BYTES) begin
                            res_next = nx;
                            ofs_next = rem_sub[fca_pkg::BOFS_W-1:0];
                        end else begin
                            state_next = S_READ;
                        end
                    end
                    default: ;
                endcase
            end
            S_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        blk_reg   <= blk_next;
        cur_reg   <= cur_next;
        rem_reg   <= rem_next;
        steps_reg <= steps_next;
        res_reg   <= res_next;
        ofs_reg   <= ofs_next;
        st_reg    <= st_next;
        if (out_load) begin
            m_res_reg  <= res_reg;
            m_ofs_reg  <= ofs_reg;
            m_head_reg <= head_reg;
            m_st_reg   <= st_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_result_block    = m_res_reg;
    assign m_offset_in_block = m_ofs_reg;
    assign m_free_head       = m_head_reg;
    assign m_status          = m_st_reg;

    // a locate walk only reads a link while a whole block remains to skip
    a_locate_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL && op_reg == fca_pkg::OP_LOCATE) |-> (rem_reg >= BLK_BYTES))
        else $error("locate walk entered with short remainder");

    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL && op_reg == fca_pkg::OP_FREE) |-> (steps_reg <= STEP_MAX))
        else $error("free walk step count overrun");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second transfer taken while busy");

    a_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid && s_ready))
        else $error("result not presented after completion");

    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (32'(wr_addr) < NUM_BLOCKS))
        else $error("table write outside depth");

endmodule

### rtl/fca_link_ram.sv
// Link table storage: one write port, one read port, registered read data.
// Depends on fca_pkg for the link width.
module fca_link_ram #(
    parameter int DEPTH = fca_pkg::NUM_BLOCKS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [fca_pkg::LINK_W-1:0] wr_data,
    input  logic [AW-1:0]              rd_addr,
    output logic [fca_pkg::LINK_W-1:0] rd_data
);

    logic [fca_pkg::LINK_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
